>>> rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and glyph table for the seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int DIGIT_COUNT    = 8;
    localparam int IDX_W          = $clog2(DIGIT_COUNT);
    localparam int GLYPH_W        = 8;
    localparam int WORD_W         = 16;
    localparam int BIT_CNT_W      = $clog2(WORD_W);

    // Input command codes
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_LITERS  = 2'd1;
    localparam logic [1:0] CMD_SECONDS = 2'd2;

    // Buffer slots touched by the write commands
    localparam logic [IDX_W-1:0] SLOT_MINUTES   = IDX_W'(0);
    localparam logic [IDX_W-1:0] SLOT_SEC_TENS  = IDX_W'(2);
    localparam logic [IDX_W-1:0] SLOT_SEC_UNITS = IDX_W'(3);
    localparam logic [IDX_W-1:0] SLOT_LIT_TENS  = IDX_W'(6);
    localparam logic [IDX_W-1:0] SLOT_LIT_UNITS = IDX_W'(7);

    localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_LITERS,
        OP_SECONDS
    } op_t;

    // One classified operation handed from the front to the back
    typedef struct packed {
        op_t                op;
        logic [GLYPH_W-1:0] glyph_a;
        logic [GLYPH_W-1:0] glyph_b;
        logic [GLYPH_W-1:0] glyph_c;
    } entry_t;

    // Active-low segment pattern; digits above nine show nine
    function automatic logic [GLYPH_W-1:0] glyph_sat(input logic [6:0] d);
        logic [GLYPH_W-1:0] g;
        unique case (d)
            7'd0:    g = 8'b1100_0000;
            7'd1:    g = 8'b1111_1001;
            7'd2:    g = 8'b1010_0100;
            7'd3:    g = 8'b1011_0000;
            7'd4:    g = 8'b1001_1001;
            7'd5:    g = 8'b1001_0010;
            7'd6:    g = 8'b1000_0010;
            7'd7:    g = 8'b1111_1000;
            7'd8:    g = 8'b1000_0000;
            default: g = 8'b1001_0000;
        endcase
        return g;
    endfunction

endpackage

>>> rtl/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front
// Accepts commands, splits values into decimal digits, pushes classified ops.
// ----------------------------------------------------------------------------
module ssd_front
    import ssd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [9:0] value,
    output logic       push_valid,
    input  logic       push_ready,
    output entry_t     push_data
);

    logic       s1_valid_reg;
    logic [1:0] cmd_reg;
    logic [9:0] value_reg;
    logic [6:0] q10_reg;
    logic [4:0] q60_reg;

    logic [17:0] prod10;
    logic [20:0] prod60;
    logic        drop;
    logic        advance;
    logic [9:0]  rem10;
    logic [9:0]  secs_full;
    logic [5:0]  secs;
    logic [2:0]  secs_tens;
    logic [5:0]  secs_units;

    // Reciprocal multiplies, exact for 10-bit values
    assign prod10 = 18'(value) * 18'd205;
    assign prod60 = 21'(value) * 21'd1093;

    assign drop       = (cmd_reg != CMD_TICK) && (cmd_reg != CMD_LITERS)
                        && (cmd_reg != CMD_SECONDS);
    assign push_valid = s1_valid_reg && !drop;
    assign advance    = s1_valid_reg && (drop || push_ready);
    assign in_ready   = !s1_valid_reg || advance;

    assign rem10     = value_reg - 10'(q10_reg) * 10'd10;
    assign secs_full = value_reg - 10'(q60_reg) * 10'd60;
    assign secs      = secs_full[5:0];

    always_comb
    begin
        priority if (secs >= 6'd50) secs_tens = 3'd5;
        else if (secs >= 6'd40)     secs_tens = 3'd4;
        else if (secs >= 6'd30)     secs_tens = 3'd3;
        else if (secs >= 6'd20)     secs_tens = 3'd2;
        else if (secs >= 6'd10)     secs_tens = 3'd1;
        else                        secs_tens = 3'd0;
    end

    assign secs_units = secs - 6'(secs_tens) * 6'd10;

    always_comb
    begin
        push_data = '{op: OP_TICK, glyph_a: GLYPH_BLANK, glyph_b: GLYPH_BLANK,
                      glyph_c: GLYPH_BLANK};
        unique case (cmd_reg)
            CMD_LITERS:
            begin
                push_data.op      = OP_LITERS;
                push_data.glyph_a = glyph_sat(q10_reg);
                push_data.glyph_b = glyph_sat(7'(rem10[3:0]));
            end
            CMD_SECONDS:
            begin
                push_data.op      = OP_SECONDS;
                push_data.glyph_a = glyph_sat(7'(q60_reg));
                push_data.glyph_b = glyph_sat(7'(secs_tens));
                push_data.glyph_c = glyph_sat(7'(secs_units[3:0]));
            end
            default:
            begin
                push_data.op = OP_TICK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= command;
            value_reg <= value;
            q10_reg   <= prod10[17:11];
            q60_reg   <= prod60[20:16];
        end
    end

endmodule

>>> rtl/ssd_queue.sv
// ----------------------------------------------------------------------------
// ssd_queue
// Small FIFO of classified ops between front and back.
// ----------------------------------------------------------------------------
module ssd_queue
    import ssd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  entry_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output entry_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/ssd_back.sv
// ----------------------------------------------------------------------------
// ssd_back
// Pattern buffer, scan index and 16-bit output serializer.
// ----------------------------------------------------------------------------
module ssd_back
    import ssd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pop_valid,
    output logic   pop_ready,
    input  entry_t pop_data,
    output logic   out_valid,
    input  logic   out_ready,
    output logic   serial_bit,
    output logic   latch_after
);

    logic [GLYPH_W-1:0]   buf_reg [DIGIT_COUNT];
    logic [IDX_W-1:0]     idx_reg;
    logic                 busy_reg;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic [WORD_W-1:0]    word_reg;

    logic                   out_take;
    logic                   last_bit;
    logic                   load_ok;
    logic                   do_pop;
    logic [DIGIT_COUNT-1:0] select;

    assign last_bit    = (cnt_reg == BIT_CNT_W'(WORD_W - 1));
    assign out_take    = busy_reg && out_ready;
    assign load_ok     = !busy_reg || (out_take && last_bit);
    assign pop_ready   = (pop_data.op != OP_TICK) || load_ok;
    assign do_pop      = pop_valid && pop_ready;
    assign select      = DIGIT_COUNT'(1) << idx_reg;

    assign out_valid   = busy_reg;
    assign serial_bit  = word_reg[WORD_W-1];
    assign latch_after = last_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            idx_reg  <= '0;
            word_reg <= '0;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                buf_reg[i] <= GLYPH_BLANK;
            end
        end
        else
        begin
            if (do_pop && (pop_data.op == OP_TICK))
            begin
                word_reg <= {select, buf_reg[idx_reg]};
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
                idx_reg  <= idx_reg + 1'b1;
            end
            else if (out_take)
            begin
                word_reg <= {word_reg[WORD_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg + 1'b1;
                if (last_bit)
                begin
                    busy_reg <= 1'b0;
                end
            end

            // Writes land while a tick shifts; its word is already captured
            if (do_pop)
            begin
                unique case (pop_data.op)
                    OP_LITERS:
                    begin
                        buf_reg[SLOT_LIT_TENS]  <= pop_data.glyph_a;
                        buf_reg[SLOT_LIT_UNITS] <= pop_data.glyph_b;
                    end
                    OP_SECONDS:
                    begin
                        buf_reg[SLOT_MINUTES]   <= pop_data.glyph_a;
                        buf_reg[SLOT_SEC_TENS]  <= pop_data.glyph_b;
                        buf_reg[SLOT_SEC_UNITS] <= pop_data.glyph_c;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

>>> rtl/seven_segment_scan_driver_top.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_top
// Eight-digit multiplexed seven-segment driver for two chained shift registers.
// ----------------------------------------------------------------------------
// A refresh tick (command 0) yields sixteen output transactions, one serial
// bit each, MSB first: the one-hot select byte of the current digit and then
// that digit's active-low pattern; latch_after is high on the sixteenth bit.
// Command 1 writes liters into digits 6 and 7, command 2 writes elapsed
// seconds as minutes in digit 0 and seconds in digits 2 and 3; quotients above
// nine show a nine. Command 3 is dropped. Writes produce no output. The input
// side takes one transaction per cycle until the op queue fills; a tick then
// occupies the serializer for 16 output transactions (one bit per cycle with
// out_ready held high), which sets the sustained tick rate. Writes behind a
// tick are applied while it shifts. On its way to the first bit, a tick passes
// the front register, the queue and the serializer load, in that order.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_top
    import ssd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [9:0] value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       serial_bit,
    output logic       latch_after
);

    // Front to queue
    logic   push_valid;
    logic   push_ready;
    entry_t push_data;

    // Queue to back
    logic   pop_valid;
    logic   pop_ready;
    entry_t pop_data;

    // Decimal split and classification
    ssd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .value      (value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouples command intake from the bit serializer
    ssd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Pattern buffer, scan index and serializer
    ssd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_bit  (serial_bit),
        .latch_after (latch_after)
    );

endmodule
